// ===== rtl/sbl_pkg.sv =====
// Shared types and constants for the 3x3 Sobel gradient stream block.
// No dependencies; every other source file but sbl_line_buf.sv refers to it by scoped names.
package sbl_pkg;

  localparam int PIXEL_W    = 8;
  localparam int MAG_W      = 8;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 2'd2;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

  // Kernel choice.
  localparam logic ORIENT_HORIZONTAL = 1'b0;
  localparam logic ORIENT_VERTICAL   = 1'b1;

  // Position flags of one pixel in the frame.
  typedef struct packed {
    logic interior;
    logic row_end;
    logic frame_end;
  } pos_t;

endpackage

// ===== rtl/sbl_stream_if.sv =====
// Valid/ready channel interfaces for the pixel input and the gradient result.
// Depends on sbl_pkg for the payload widths.
interface sbl_pix_if;
  logic                        valid;
  logic                        ready;
  logic [sbl_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sbl_res_if;
  logic                      valid;
  logic                      ready;
  logic [sbl_pkg::MAG_W-1:0] magnitude;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output magnitude, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input magnitude, input row_end, input frame_end,
                  output ready);
endinterface

// ===== rtl/sbl_line_buf.sv =====
// One line store: a simple dual-port RAM with one write port and one
// registered read port. No dependencies.
module sbl_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sbl_pos_ctr.sv =====
// Column and row counters with clamped frame sizes; flags each accepted pixel.
// Depends on sbl_pkg for pos_t and the configuration widths.
module sbl_pos_ctr #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [sbl_pkg::CFG_W_BITS-1:0]   cfg_width,
  input  logic [sbl_pkg::CFG_H_BITS-1:0]   cfg_height,
  output logic [$clog2(MAX_WIDTH)-1:0]     col_addr,
  output sbl_pkg::pos_t                    pos
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = (CW + 1 > sbl_pkg::CFG_W_BITS) ? CW + 1 : sbl_pkg::CFG_W_BITS;
  localparam int HW = (RW + 1 > sbl_pkg::CFG_H_BITS) ? RW + 1 : sbl_pkg::CFG_H_BITS;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [EW-1:0] w_ext, w_eff;
  logic [HW-1:0] h_ext, h_eff;
  logic          last_col, last_row;

  always_comb begin
    w_ext = EW'(cfg_width);
    h_ext = HW'(cfg_height);
    if (w_ext < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < HW'(3)) begin
      h_eff = HW'(3);
    end else if (h_ext > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  // A counter at or past its last position wraps, which also covers a size
  // that shrank between frames.
  assign last_col = ((EW + 1)'(col_r) + (EW + 1)'(1)) >= (EW + 1)'(w_eff);
  assign last_row = ((HW + 1)'(row_r) + (HW + 1)'(1)) >= (HW + 1)'(h_eff);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : RW'(row_r + RW'(1));
    end else begin
      col_nxt = CW'(col_r + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col_addr      = col_r;
  assign pos.interior  = (col_r >= CW'(2)) && (row_r >= RW'(2));
  assign pos.row_end   = last_col;
  assign pos.frame_end = last_col && last_row;

endmodule

// ===== rtl/sbl_kernel.sv =====
// Six-pixel window of the two previous columns and the Sobel sum for the
// current column; gives |sum| / 4. Depends on sbl_pkg for widths and codes.
module sbl_kernel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift,
  input  logic                        orient,
  input  logic [sbl_pkg::PIXEL_W-1:0] up,
  input  logic [sbl_pkg::PIXEL_W-1:0] mid,
  input  logic [sbl_pkg::PIXEL_W-1:0] px,
  output logic [sbl_pkg::MAG_W-1:0]   magnitude
);

  // Index 0 is column c-2, index 1 column c-1.
  logic [sbl_pkg::PIXEL_W-1:0] top_r [2];
  logic [sbl_pkg::PIXEL_W-1:0] cen_r [2];
  logic [sbl_pkg::PIXEL_W-1:0] bot_r [2];

  logic signed [10:0] t0, t1, t2, c0, c2, b0, b1, b2;
  logic signed [10:0] sum;
  logic        [9:0]  abs_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '{default: '0};
      cen_r <= '{default: '0};
      bot_r <= '{default: '0};
    end else if (shift) begin
      top_r[0] <= top_r[1];
      top_r[1] <= up;
      cen_r[0] <= cen_r[1];
      cen_r[1] <= mid;
      bot_r[0] <= bot_r[1];
      bot_r[1] <= px;
    end
  end

  always_comb begin
    t0 = signed'({3'b000, top_r[0]});
    t1 = signed'({3'b000, top_r[1]});
    t2 = signed'({3'b000, up});
    c0 = signed'({3'b000, cen_r[0]});
    c2 = signed'({3'b000, mid});
    b0 = signed'({3'b000, bot_r[0]});
    b1 = signed'({3'b000, bot_r[1]});
    b2 = signed'({3'b000, px});
    unique case (orient)
      sbl_pkg::ORIENT_HORIZONTAL: sum = (t2 - t0) + ((c2 - c0) <<< 1) + (b2 - b0);
      sbl_pkg::ORIENT_VERTICAL:   sum = (b0 + (b1 <<< 1) + b2) - (t0 + (t1 <<< 1) + t2);
      default:                    sum = '0;
    endcase
    // The sum stays within +/-1020, so its magnitude fits ten bits.
    abs_v = 10'(sum[10] ? -sum : sum);
  end

  // Dropping two bits of the magnitude is division by four toward zero.
  assign magnitude = abs_v[9:2];

endmodule

// ===== rtl/sobel_gradient_3x3_stream.sv =====
// Top level of the 3x3 Sobel gradient stream: configuration registers,
// request pipeline and result register. Uses sbl_pkg, the stream interfaces,
// sbl_pos_ctr, sbl_line_buf and sbl_kernel.
//
//   channel  | direction | payload                          | request when
//   in_chan  | sink      | pixel[7:0]                       | valid && ready
//   out_chan | source    | magnitude[7:0] row_end frame_end | valid && ready
//   cfg_*    | write     | cfg_index[1:0] cfg_data[12:0]    | cfg_we
//
// One pixel per cycle while no interior result waits on a stalled output; a taken
// pixel goes through the line store read, then the kernel into the result register.
// The line store read port registers its data, which sets the extra stage.
// Synchronous active-low reset clears counters, window and valid flags;
// line stores hold unknown data until written by the first two rows.
// A stalled result holds in the output register while the next pixel still
// moves into the read stage; border pixels pass without a result slot.
module sobel_gradient_3x3_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sbl_pix_if.sink                        in_chan,
  sbl_res_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [sbl_pkg::CFG_W_BITS-1:0] width_r;
  logic [sbl_pkg::CFG_H_BITS-1:0] height_r;
  logic                           orient_r;

  logic                        accept;
  logic [CW-1:0]               col_addr;
  sbl_pkg::pos_t               pos;

  logic                        s1_v_r;
  logic [sbl_pkg::PIXEL_W-1:0] s1_px_r;
  sbl_pkg::pos_t               s1_pos_r;
  logic [CW-1:0]               s1_addr_r;
  logic                        s1_go;
  logic [sbl_pkg::PIXEL_W-1:0] rd_upper, rd_middle;
  logic [sbl_pkg::MAG_W-1:0]   mag;

  logic                        out_v_r;
  logic [sbl_pkg::MAG_W-1:0]   out_mag_r;
  logic                        out_row_end_r;
  logic                        out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sbl_pkg::WIDTH_RESET;
      height_r <= sbl_pkg::HEIGHT_RESET;
      orient_r <= sbl_pkg::ORIENT_HORIZONTAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbl_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[sbl_pkg::CFG_W_BITS-1:0];
        sbl_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[sbl_pkg::CFG_H_BITS-1:0];
        sbl_pkg::REG_ORIENTATION:  orient_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A border pixel needs no result slot, so it never waits on the output.
  assign s1_go  = s1_v_r && (!s1_pos_r.interior || !out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || s1_go;
  assign accept = in_chan.valid && in_chan.ready;

  sbl_pos_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .col_addr   (col_addr),
    .pos        (pos)
  );

  // Reads happen at the request; writes happen one stage later at the
  // previous column, so a read and a write never meet at one address.
  sbl_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (sbl_pkg::PIXEL_W)
  ) u_upper (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr_r),
    .wdata (rd_middle),
    .re    (accept),
    .raddr (col_addr),
    .rdata (rd_upper)
  );

  sbl_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (sbl_pkg::PIXEL_W)
  ) u_middle (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr_r),
    .wdata (s1_px_r),
    .re    (accept),
    .raddr (col_addr),
    .rdata (rd_middle)
  );

  sbl_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (s1_go),
    .orient    (orient_r),
    .up        (rd_upper),
    .mid       (rd_middle),
    .px        (s1_px_r),
    .magnitude (mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_chan.pixel;
      s1_pos_r  <= pos;
      s1_addr_r <= col_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_pos_r.interior) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_pos_r.interior) begin
      out_mag_r       <= mag;
      out_row_end_r   <= s1_pos_r.row_end;
      out_frame_end_r <= s1_pos_r.frame_end;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.magnitude = out_mag_r;
  assign out_chan.row_end   = out_row_end_r;
  assign out_chan.frame_end = out_frame_end_r;

endmodule

// ===== rtl/sbl_checker.sv =====
// Port-level checks for the Sobel gradient stream and the bind that attaches
// them to the top level. Depends on sbl_pkg and sobel_gradient_3x3_stream.
module sbl_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sbl_pkg::MAG_W-1:0] out_magnitude,
  input logic                      out_row_end,
  input logic                      out_frame_end
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // The last result of a frame is also the last result of its row.
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sobel_gradient_3x3_stream sbl_checker u_sbl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_magnitude (out_chan.magnitude),
  .out_row_end   (out_chan.row_end),
  .out_frame_end (out_chan.frame_end)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_gradient_3x3_stream: predicts every gradient result
// of directed and random pixel frames and compares it on the result channel.
// Depends on sbl_pkg, the stream interfaces in sbl_stream_if.sv and the block RTL.
module tb_top;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 300;

  typedef logic [sbl_pkg::PIXEL_W-1:0]    pixel_t;
  typedef logic [sbl_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [sbl_pkg::MAG_W-1:0] magnitude;
    logic                      row_end;
    logic                      frame_end;
  } grad_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sbl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sbl_pkg::CFG_DATA_W-1:0] cfg_data;

  sbl_pix_if pix_ch ();
  sbl_res_if res_ch ();

  sobel_gradient_3x3_stream #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk,
    .rst_n,
    .in_chan  (pix_ch),
    .out_chan (res_ch),
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  always #5 clk = ~clk;

  // Shadow of the block: registers, line stores, window and raster position.
  logic [sbl_pkg::CFG_W_BITS-1:0] width_reg;
  logic [sbl_pkg::CFG_H_BITS-1:0] height_reg;
  logic                           orient_reg;
  pixel_t                         upper_line  [MAX_WIDTH];
  pixel_t                         middle_line [MAX_WIDTH];
  pixel_t                         window_px   [6];
  int                             col_pos;
  int                             row_pos;

  grad_result_t grad_expected [$];
  int failures    = 0;
  int pixels_sent = 0;
  int send_calm   = 0;
  int hold_req    = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int frame_width();
    return clamp_dim(int'(width_reg), MAX_WIDTH);
  endfunction

  function automatic int frame_height();
    return clamp_dim(int'(height_reg), MAX_HEIGHT);
  endfunction

  function automatic pixel_t rand_pixel(input bit harsh);
    if (harsh && $urandom_range(0, 3) != 0)
      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return pixel_t'($urandom_range(0, 255));
  endfunction

  task automatic predict_gradient(input pixel_t px);
    int           w;
    int           h;
    int           sum;
    int           mag;
    pixel_t       up;
    pixel_t       mid;
    grad_result_t res;
    w   = frame_width();
    h   = frame_height();
    up  = upper_line[col_pos];
    mid = middle_line[col_pos];
    if (row_pos >= 2 && col_pos >= 2) begin
      if (orient_reg == sbl_pkg::ORIENT_HORIZONTAL)
        sum = (int'(up) - int'(window_px[0])) + 2 * (int'(mid) - int'(window_px[2]))
            + (int'(px) - int'(window_px[4]));
      else
        sum = (int'(window_px[4]) + 2 * int'(window_px[5]) + int'(px))
            - (int'(window_px[0]) + 2 * int'(window_px[1]) + int'(up));
      // Taking the absolute value first gives truncation toward zero.
      mag = ((sum < 0) ? -sum : sum) / 4;
      res.magnitude = mag[sbl_pkg::MAG_W-1:0];
      res.row_end   = (col_pos + 1 >= w);
      res.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
      grad_expected.push_back(res);
    end
    window_px[0] = window_px[1];
    window_px[1] = up;
    window_px[2] = window_px[3];
    window_px[3] = mid;
    window_px[4] = window_px[5];
    window_px[5] = px;
    upper_line[col_pos]  = mid;
    middle_line[col_pos] = px;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic write_reg(input logic [sbl_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      sbl_pkg::REG_IMAGE_WIDTH:  width_reg  = val[sbl_pkg::CFG_W_BITS-1:0];
      sbl_pkg::REG_IMAGE_HEIGHT: height_reg = val[sbl_pkg::CFG_H_BITS-1:0];
      sbl_pkg::REG_ORIENTATION:  orient_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic program_sizes(input cfg_word_t w_val,
                               input cfg_word_t h_val,
                               input logic orient);
    write_reg(sbl_pkg::REG_IMAGE_WIDTH, w_val);
    write_reg(sbl_pkg::REG_IMAGE_HEIGHT, h_val);
    write_reg(sbl_pkg::REG_ORIENTATION, cfg_word_t'(orient));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t px);
    forever begin
      if (send_calm > 0) begin
        send_calm--;
        break;
      end
      if ($urandom_range(0, 999) < 2) begin
        send_calm = 300;
        break;
      end
      if ($urandom_range(0, 99) >= 26) break;
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(negedge clk); while (pix_ch.ready !== 1'b1);
    @(posedge clk);
    predict_gradient(px);
    pixels_sent++;
  endtask

  // Sends pixels until the raster position wraps back to the frame start.
  task automatic finish_frame(input bit harsh);
    do send_pixel(rand_pixel(harsh)); while (col_pos != 0 || row_pos != 0);
  endtask

  // Stops sending, lets every outstanding result drain, then waits out the pipeline.
  task automatic settle_block();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (grad_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_sizes();
    // One full row and the start of the next at the reset width; no result may
    // appear before the third row.
    repeat (int'(sbl_pkg::WIDTH_RESET) + 5) send_pixel(rand_pixel(1'b0));
    settle_block();
    // Row 1, column 5 stays inside the narrower frame; the kernel keeps its reset choice.
    write_reg(sbl_pkg::REG_IMAGE_WIDTH, cfg_word_t'(8));
    write_reg(sbl_pkg::REG_IMAGE_HEIGHT, cfg_word_t'(4));
    cfg_we <= 1'b0;
    @(posedge clk);
    finish_frame(1'b0);
  endtask

  task automatic test_kernel_extremes();
    pixel_t pattern [24] = '{
      8'd0,   8'd128, 8'd255,  8'd0, 8'd128, 8'd255,
      8'd0,   8'd128, 8'd255,  8'd7, 8'd200, 8'd0,
      8'd255, 8'd255, 8'd255,  8'd0, 8'd3,   8'd1,
      8'd0,   8'd0,   8'd0,    8'd0, 8'd0,   8'd0
    };
    settle_block();
    program_sizes(cfg_word_t'(1), cfg_word_t'(4), sbl_pkg::ORIENT_HORIZONTAL);
    for (int i = 0; i < 12; i++) send_pixel(pattern[i]);
    settle_block();
    // The second window sums to -7 and must give 1, not 2.
    program_sizes(cfg_word_t'(1), cfg_word_t'(4), sbl_pkg::ORIENT_VERTICAL);
    for (int i = 12; i < 24; i++) send_pixel(pattern[i]);
  endtask

  task automatic test_size_extremes();
    settle_block();
    // The widest setting clamps to the line store depth; narrowing below the
    // floor then wraps the column on the next pixel.
    program_sizes(cfg_word_t'(2047), cfg_word_t'(0), sbl_pkg::ORIENT_HORIZONTAL);
    repeat (30) send_pixel(rand_pixel(1'b1));
    settle_block();
    program_sizes(cfg_word_t'(0), cfg_word_t'(1), sbl_pkg::ORIENT_VERTICAL);
    finish_frame(1'b1);
    finish_frame(1'b0);
    settle_block();
    // The tallest setting clamps high, so rows run well past three.
    program_sizes(cfg_word_t'(2), cfg_word_t'(8191), sbl_pkg::ORIENT_HORIZONTAL);
    repeat (20) send_pixel(rand_pixel(1'b0));
    settle_block();
    program_sizes(cfg_word_t'(2), cfg_word_t'(2), sbl_pkg::ORIENT_HORIZONTAL);
    finish_frame(1'b0);
  endtask

  task automatic test_backpressure();
    settle_block();
    program_sizes(cfg_word_t'(8), cfg_word_t'(6), sbl_pkg::ORIENT_HORIZONTAL);
    repeat (20) send_pixel(rand_pixel(1'b0));
    // The receiver holds off while requests keep coming, so the input must stall.
    hold_req  = 120;
    send_calm = 200;
    repeat (16) send_pixel(rand_pixel(1'b1));
    send_calm = 0;
    settle_block();
    finish_frame(1'b0);
  endtask

  task automatic test_random_frames();
    int start;
    int w_val;
    int h_val;
    int pick;
    int n;
    bit harsh;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      settle_block();
      pick  = $urandom_range(0, 9);
      w_val = (pick == 0) ? $urandom_range(0, 2) :
              (pick == 1) ? $urandom_range(17, 40) : $urandom_range(3, 16);
      h_val = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      program_sizes(cfg_word_t'(w_val), cfg_word_t'(h_val), 1'($urandom_range(0, 1)));
      harsh = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // Stop past the first two rows; a narrower width only reads filled entries.
        n = 2 * frame_width() + $urandom_range(0, frame_width() * (frame_height() - 2) - 1);
        repeat (n) send_pixel(rand_pixel(harsh));
        settle_block();
        program_sizes(cfg_word_t'($urandom_range(0, frame_width())),
                      cfg_word_t'($urandom_range(0, 10)), 1'($urandom_range(0, 1)));
      end
      finish_frame(harsh);
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      failures++;
    end
  endtask

  initial begin : result_monitor
    grad_result_t want;
    int           stall_left;
    int           recv_calm;
    stall_left   = 0;
    recv_calm    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (recv_calm > 0) begin
        res_ch.ready <= 1'b1;
        recv_calm--;
      end else if ($urandom_range(0, 999) < 3) begin
        res_ch.ready <= 1'b1;
        recv_calm = 300;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= 26);
      end
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (grad_expected.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got magnitude %0d", $time,
                   res_ch.magnitude);
          failures++;
        end else begin
          want = grad_expected.pop_front();
          check_field("magnitude", want.magnitude, res_ch.magnitude);
          check_field("row_end", 8'(want.row_end), 8'(res_ch.row_end));
          check_field("frame_end", 8'(want.frame_end), 8'(res_ch.frame_end));
        end
      end
    end
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = sbl_pkg::REG_IMAGE_WIDTH;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    width_reg    = sbl_pkg::WIDTH_RESET;
    height_reg   = sbl_pkg::HEIGHT_RESET;
    orient_reg   = sbl_pkg::ORIENT_HORIZONTAL;
    col_pos      = 0;
    row_pos      = 0;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (middle_line[i]) middle_line[i] = '0;
    foreach (window_px[i]) window_px[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_sizes();
    test_kernel_extremes();
    test_size_extremes();
    test_backpressure();
    test_random_frames();

    settle_block();
    if (failures == 0 && grad_expected.size() == 0) begin
      $display("** sobel_gradient_3x3_stream: PASSED **");
    end else begin
      $display("** sobel_gradient_3x3_stream: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("** sobel_gradient_3x3_stream: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sbl_pkg.sv
rtl/sbl_stream_if.sv
rtl/sbl_line_buf.sv
rtl/sbl_pos_ctr.sv
rtl/sbl_kernel.sv
rtl/sobel_gradient_3x3_stream.sv
rtl/sbl_checker.sv
tb/sv/tb_top.sv
